@@ rtl/core/sida_pkg.sv @@
`timescale 1ns / 1ps

package sida_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } sida_cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OOB  = 2'd2
  } sida_status_e;

  // what every cell of the row does in this cycle
  typedef enum logic [1:0] {
    OP_KEEP = 2'd0,
    OP_WR   = 2'd1,
    OP_INS  = 2'd2,
    OP_DEL  = 2'd3
  } sida_op_e;

  typedef struct packed {
    logic             en;
    sida_op_e         kind;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] val;
  } sida_op_t;

  typedef struct packed {
    sida_status_e    status;
    logic [CntW-1:0] length;
    logic [CntW-1:0] count;
  } sida_stat_t;

endpackage

@@ rtl/core/sida_cell.sv @@
`timescale 1ns / 1ps

module sida_cell (
  input  logic                              clk_i,
  input  logic [sida_pkg::IdxW-1:0]         cell_idx_i,
  input  sida_pkg::sida_op_t                op_i,
  input  logic [sida_pkg::DataW-1:0]        left_i,
  input  logic [sida_pkg::DataW-1:0]        right_i,
  output logic [sida_pkg::DataW-1:0]        data_o
);
  import sida_pkg::*;

  logic [DataW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (op_i.kind)
      OP_WR: begin
        if (cell_idx_i == op_i.idx) data_d = op_i.val;
      end
      OP_INS: begin
        if (cell_idx_i == op_i.idx) begin
          data_d = op_i.val;
        end else if (cell_idx_i > op_i.idx) begin
          data_d = left_i;
        end
      end
      OP_DEL: begin
        if (cell_idx_i >= op_i.idx) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/sida_ctrl.sv @@
`timescale 1ns / 1ps

module sida_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  sida_pkg::sida_cmd_e        cmd_i,
  input  logic [sida_pkg::IdxW-1:0]  idx_i,
  input  logic [sida_pkg::DataW-1:0] val_i,
  output sida_pkg::sida_op_t         op_o,
  output sida_pkg::sida_stat_t       stat_o
);
  import sida_pkg::*;

  logic [CntW-1:0] count_d, count_q;
  logic [CntW-1:0] idx_ext;
  logic            full;
  sida_status_e    status;
  sida_op_e        kind;
  logic [IdxW-1:0] tgt;

  assign idx_ext = {1'b0, idx_i};
  assign full    = (count_q >= CntW'(Capacity));

  always_comb begin
    status  = ST_OK;
    kind    = OP_KEEP;
    tgt     = idx_i;
    count_d = count_q;
    case (cmd_i)
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          kind    = OP_WR;
          tgt     = count_q[IdxW-1:0];
          count_d = count_q + CntW'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (idx_ext > count_q) begin
          status = ST_OOB;
        end else begin
          kind    = OP_INS;
          count_d = count_q + CntW'(1);
        end
      end
      CMD_WRITE: begin
        if (idx_ext >= count_q) status = ST_OOB;
        else kind = OP_WR;
      end
      CMD_DELETE: begin
        if (idx_ext >= count_q) begin
          status = ST_OOB;
        end else begin
          kind    = OP_DEL;
          count_d = count_q - CntW'(1);
        end
      end
      CMD_READ: begin
        if (idx_ext >= count_q) status = ST_OOB;
      end
      default: status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign op_o.en   = accept_i;
  assign op_o.kind = kind;
  assign op_o.idx  = tgt;
  assign op_o.val  = val_i;

  assign stat_o.status = status;
  assign stat_o.length = count_d;
  assign stat_o.count  = count_q;

endmodule

@@ rtl/core/shift_insert_delete_array_top.sv @@
`timescale 1ns / 1ps
// Ordered array of up to 16 signed 32-bit words with append, insert, overwrite,
// delete and read commands.
// Input channel s_axis: command in tuser, index and value in tdata.
// Output channel m_axis: status in tuser, read word and new length in tdata.
// Every input beat produces exactly one output beat.
// The result is registered and appears in the cycle after the input beat is taken.
// Throughput: one command per cycle while the receiver takes results; the row of
// cells shifts all entries at once on insert and delete, so these take no longer than other commands.
// The output register holds a result until m_axis_tready_i is high; while it
// is held, s_axis_tready_o stays low only if the receiver is stalling, and
// goes high again in the cycle the result is taken.
// Reset empties the array (length zero) and drops any pending result; the
// word storage itself is not cleared, entries beyond the length are never read.
// Read returns zero in read_value for every command other than a good read.

module shift_insert_delete_array_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [3:0] index, [35:4] value, rest zero
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [31:0] read_value, [36:32] length
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import sida_pkg::*;

  logic             accept;
  sida_cmd_e        cmd;
  logic [IdxW-1:0]  idx;
  logic [DataW-1:0] val;
  sida_op_t         op;
  sida_stat_t       stat;
  logic [DataW-1:0] cell_data [Capacity];
  logic [DataW-1:0] rd;

  logic             m_valid_d, m_valid_q;
  sida_status_e     m_status_q;
  logic [DataW-1:0] m_rd_q;
  logic [CntW-1:0]  m_len_q;

  assign cmd = sida_cmd_e'(s_axis_tuser_i);
  assign idx = s_axis_tdata_i[IdxW-1:0];
  assign val = s_axis_tdata_i[IdxW+DataW-1:IdxW];

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  sida_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd),
    .idx_i    (idx),
    .val_i    (val),
    .op_o     (op),
    .stat_o   (stat)
  );

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    sida_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IdxW'(g)),
      .op_i       (op),
      .left_i     (left),
      .right_i    (right),
      .data_o     (cell_data[g])
    );
  end

  assign rd = (cmd == CMD_READ && stat.status == ST_OK) ? cell_data[idx] : '0;

  always_comb begin
    m_valid_d = m_valid_q;
    if (accept) m_valid_d = 1'b1;
    else if (m_axis_tready_i) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_status_q <= stat.status;
      m_rd_q     <= rd;
      m_len_q    <= stat.length;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {3'b000, m_len_q, m_rd_q};

  // length never exceeds the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CntW'(Capacity))
    else $error("count above capacity");

  // a taken beat always shows up on the output in the next cycle
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("result missing after accepted beat");

  // reported length is the count the controller holds afterwards
  a_len_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (m_len_q == stat.count))
    else $error("length does not match count");

  // a full status is only reported with a full array
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == ST_FULL) |-> (m_len_q == CntW'(Capacity)))
    else $error("full status with room left");

  // nonzero read word only on a good result
  a_rd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_rd_q != '0) |-> (m_status_q == ST_OK))
    else $error("read word on failed command");

endmodule

@@ tb/sv/tb_shift_insert_delete_array_top.sv @@
`timescale 1ns / 1ps

module tb_shift_insert_delete_array_top;
  import sida_pkg::*;

  // longest correct quiet stretch is a sender gap plus a receiver stall
  localparam int unsigned StallLimit = 1000;

  typedef struct packed {
    sida_status_e     status;
    logic [DataW-1:0] rd;
    logic [CntW-1:0]  len;
  } arr_resp_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;  // [3:0] index, [35:4] value, rest zero
  logic [2:0]  s_axis_tuser_i  = '0;  // [2:0] command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] read_value, [36:32] length
  logic [1:0]  m_axis_tuser_o;        // [1:0] status

  // shadow copy of the array contents
  logic [DataW-1:0] arr_cells [Capacity];
  int unsigned      arr_len = 0;
  arr_resp_t        pending_resp_q [$];
  int unsigned      err_cnt = 0;
  int unsigned      beat_cnt = 0;
  int unsigned      idle_cycles = 0;
  bit               tx_idle = 1'b0;
  bit               rx_idle = 1'b0;

  logic [DataW-1:0] corner_vals [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

  shift_insert_delete_array_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // applies one command to the shadow array and returns the response it should give
  function automatic arr_resp_t apply_cmd(logic [2:0] cmd, logic [IdxW-1:0] idx,
                                          logic [DataW-1:0] val);
    arr_resp_t   r;
    int unsigned i;
    r.status = ST_OK;
    r.rd     = '0;
    case (cmd)
      CMD_APPEND: begin
        if (arr_len >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          arr_cells[arr_len] = val;
          arr_len++;
        end
      end
      CMD_INSERT: begin
        // full wins over a bad index
        if (arr_len >= Capacity) begin
          r.status = ST_FULL;
        end else if (idx > arr_len) begin
          r.status = ST_OOB;
        end else begin
          for (i = arr_len; i > idx; i--) arr_cells[i] = arr_cells[i-1];
          arr_cells[idx] = val;
          arr_len++;
        end
      end
      CMD_WRITE: begin
        if (idx >= arr_len) r.status = ST_OOB;
        else arr_cells[idx] = val;
      end
      CMD_DELETE: begin
        if (idx >= arr_len) begin
          r.status = ST_OOB;
        end else begin
          for (i = idx; i + 1 < arr_len; i++) arr_cells[i] = arr_cells[i+1];
          arr_len--;
        end
      end
      CMD_READ: begin
        if (idx >= arr_len) r.status = ST_OOB;
        else r.rd = arr_cells[idx];
      end
      default: ;
    endcase
    r.len = CntW'(arr_len);
    return r;
  endfunction

  // called just after the clock rises; returns in the step of the handshake
  task automatic push_cmd(input logic [2:0] cmd, input logic [IdxW-1:0] idx,
                          input logic [DataW-1:0] val);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, val, idx};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    pending_resp_q.push_back(apply_cmd(cmd, idx, val));
  endtask

  task automatic test_directed();
    int unsigned c;
    // empty array: everything indexed is out of range except an insert at zero
    push_cmd(CMD_READ,   4'd0, 32'h0);
    push_cmd(CMD_DELETE, 4'd0, 32'h0);
    push_cmd(CMD_WRITE,  4'd0, 32'h1);
    push_cmd(CMD_INSERT, 4'd1, 32'h2);
    push_cmd(CMD_INSERT, 4'd0, 32'h8000_0000);
    push_cmd(CMD_APPEND, 4'd15, 32'h7fff_ffff);
    push_cmd(CMD_APPEND, 4'd9, 32'hffff_ffff);
    push_cmd(CMD_APPEND, 4'd0, 32'h0);
    // insert at the end behaves as append, in the middle shifts up
    push_cmd(CMD_INSERT, 4'd4, 32'h5555_5555);
    push_cmd(CMD_INSERT, 4'd2, 32'haaaa_aaaa);
    push_cmd(CMD_WRITE,  4'd6, 32'hdead_beef);
    push_cmd(CMD_WRITE,  4'd5, 32'h1234_5678);
    push_cmd(CMD_READ,   4'd5, 32'hffff_ffff);
    push_cmd(CMD_READ,   4'd0, 32'h0);
    push_cmd(CMD_DELETE, 4'd5, 32'h0);
    push_cmd(CMD_DELETE, 4'd0, 32'h0);
    push_cmd(CMD_READ,   4'd4, 32'h0);
    for (c = int'(CMD_READ) + 1; c < 8; c++) push_cmd(3'(c), 4'hf, 32'hffff_ffff);
    // fill up, then hit the full cases and the top slot
    while (arr_len < Capacity) push_cmd(CMD_APPEND, 4'(arr_len), $urandom);
    push_cmd(CMD_APPEND, 4'd0, 32'h1);
    push_cmd(CMD_INSERT, 4'd15, 32'h2);
    push_cmd(CMD_READ,   4'd15, 32'h0);
    push_cmd(CMD_WRITE,  4'd15, 32'h8000_0000);
    push_cmd(CMD_DELETE, 4'd15, 32'h0);
  endtask

  // bias picks a mostly growing, mostly shrinking or balanced command mix
  task automatic test_random(input int unsigned n_items);
    int unsigned      cut [3][5] = '{'{40, 60, 70, 78, 97}, '{8, 15, 25, 65, 97},
                                     '{20, 40, 55, 75, 97}};
    sida_cmd_e        ops [5] = '{CMD_APPEND, CMD_INSERT, CMD_WRITE, CMD_DELETE, CMD_READ};
    int unsigned      bias;
    int unsigned      roll;
    int unsigned      hi;
    int               j;
    logic [2:0]       cmd;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] val;
    bias = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 40 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      cmd  = 3'($urandom_range(int'(CMD_READ) + 1, 7));
      for (j = 4; j >= 0; j--) if (roll < cut[bias][j]) cmd = ops[j];
      hi  = (arr_len > 15) ? 15 : arr_len;
      idx = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, hi));
      val = ($urandom_range(0, 7) == 0) ? corner_vals[$urandom_range(0, 3)] : $urandom;
      push_cmd(cmd, idx, val);
    end
  endtask

  // sender goes quiet until every outstanding beat has drained
  task automatic test_hold_off();
    repeat (3) begin
      test_random(12);
      s_axis_tvalid_i <= 1'b0;
      wait (pending_resp_q.size() == 0);
      @(posedge clk_i);
    end
  endtask

  initial begin : rx_check
    arr_resp_t   exp_resp;
    int unsigned stall;
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
      beat_cnt++;
      if (pending_resp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("beat %0d: result with nothing pending", beat_cnt);
      end else begin
        exp_resp = pending_resp_q.pop_front();
        if (m_axis_tuser_o != exp_resp.status || m_axis_tdata_o[31:0] != exp_resp.rd ||
            m_axis_tdata_o[36:32] != exp_resp.len) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("beat %0d: exp status %0d read %h len %0d, got status %0d read %h len %0d",
                     beat_cnt, exp_resp.status, exp_resp.rd, exp_resp.len,
                     m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[36:32]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("shift_insert_delete_array_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_random(300);
    test_hold_off();
    rx_idle = 1'b0;
    test_random(300);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    test_random(300);
    rx_idle = 1'b0;
    test_random(300);
    s_axis_tvalid_i <= 1'b0;
    wait (pending_resp_q.size() == 0);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("shift_insert_delete_array_top: match");
    end else begin
      $display("shift_insert_delete_array_top: mismatch");
    end
    $finish;
  end

endmodule
